/* sv/rama_pkg.sv */
// Package: payload words, status codes and sequencer states for the rational unit.
`timescale 1ns / 1ps
`default_nettype none
package rama_pkg;

  localparam int DIV_BITS = 64;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZDEN = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  typedef enum logic {
    ACT_ADD = 1'b0,
    ACT_MUL = 1'b1
  } action_t;

  typedef struct packed {
    logic               action;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    status_t            status;
  } out_word_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_MULN, S_MULD, S_GCD, S_GCDW, S_QA, S_QAW, S_QB, S_QBW,
    S_LCD, S_TA, S_TB, S_COMB, S_RED, S_RN, S_RNW, S_RD, S_RDW, S_OUT
  } state_t;

endpackage
`default_nettype wire

/* sv/rama_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rama_div
  import rama_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [DIV_BITS-1:0] dividend,
  input  wire logic [DIV_BITS-1:0] divisor,
  output logic                     done,
  output logic [DIV_BITS-1:0]      quo,
  output logic [DIV_BITS-1:0]      rem
);

  localparam int CW = $clog2(DIV_BITS);

  logic                run_r;
  logic                done_r;
  logic [CW-1:0]       cnt_r;
  logic [DIV_BITS-1:0] d_r;
  logic [DIV_BITS-1:0] quo_r;
  logic [DIV_BITS-1:0] rem_r;
  logic [DIV_BITS:0]   rem_sh;
  logic [DIV_BITS:0]   diff;
  logic                ge;

  always_comb begin
    rem_sh = {rem_r, quo_r[DIV_BITS-1]};
    diff   = rem_sh - {1'b0, d_r};
    ge     = !diff[DIV_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(DIV_BITS - 1);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= divisor;
      quo_r <= dividend;
      rem_r <= '0;
    end else if (run_r) begin
      quo_r <= {quo_r[DIV_BITS-2:0], ge};
      rem_r <= ge ? diff[DIV_BITS-1:0] : rem_sh[DIV_BITS-1:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

/* sv/rational_add_multiply_reduce_unit.sv */
// Top level: sequencer, shared multiplier and divider for fraction add/multiply.
`timescale 1ns / 1ps
`default_nettype none
// Adds or multiplies two 32-bit fractions and returns the result in lowest
// terms with a positive denominator. Raise start while busy is low; the word
// is taken on that edge and busy stays high until the result is shown. The
// result appears for exactly one cycle with out_valid high and cannot be held
// off. Latency is data dependent: every remainder or quotient goes through
// one bit-serial divider, whose pass launches, forms 64 quotient bits and
// signals done. The passes are, for add, the Euclid steps of
// gcd(|a_den|,|b_den|) plus 2, then for both operations, unless the sum or
// product is zero, the Euclid steps of the final reduction plus 2. A zero
// denominator input goes from S_IDLE to S_CHECK and straight back to
// S_IDLE, and its result is shown as it returns.
module rational_add_multiply_reduce_unit
  import rama_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  output out_word_t      out_data
);

  localparam logic [63:0] LIM = 64'd1 << (WORD_BITS - 1);

  state_t state_r, state_nxt;

  logic        act_r;
  logic [31:0] ma_r, da_r, mb_r, db_r, qa_r, qb_r;
  logic        sa_r, sb_r, neg_r, phase_r;
  logic [63:0] x_r, y_r, mag_r, den_r, ta_r, tb_r;
  logic        out_valid_r;
  out_word_t   out_r;

  logic        div_start, div_done;
  logic [63:0] div_n, div_d, div_q, div_rem;
  logic [31:0] mul_x, mul_y;
  logic [63:0] prod;
  logic        ovf;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  rama_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quo      (div_q),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_n     = x_r;
    div_d     = y_r;
    mul_x     = ma_r;
    mul_y     = mb_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_CHECK;
      S_CHECK: begin
        if (da_r == '0 || db_r == '0) state_nxt = S_IDLE;
        else if (act_r == ACT_MUL)    state_nxt = S_MULN;
        else                          state_nxt = S_GCD;
      end
      S_MULN:  state_nxt = S_MULD;
      S_MULD: begin
        mul_x = da_r;
        mul_y = db_r;
        state_nxt = S_RED;
      end
      S_GCD: begin
        if (y_r == '0) begin
          state_nxt = phase_r ? S_RN : S_QA;
        end else begin
          div_start = 1'b1;
          state_nxt = S_GCDW;
        end
      end
      S_GCDW: if (div_done) state_nxt = S_GCD;
      S_QA: begin
        div_start = 1'b1;
        div_n     = {32'd0, da_r};
        div_d     = x_r;
        state_nxt = S_QAW;
      end
      S_QAW: if (div_done) state_nxt = S_QB;
      S_QB: begin
        div_start = 1'b1;
        div_n     = {32'd0, db_r};
        div_d     = x_r;
        state_nxt = S_QBW;
      end
      S_QBW: if (div_done) state_nxt = S_LCD;
      S_LCD: begin
        mul_x = qa_r;
        mul_y = db_r;
        state_nxt = S_TA;
      end
      S_TA: begin
        mul_x = ma_r;
        mul_y = qb_r;
        state_nxt = S_TB;
      end
      S_TB: begin
        mul_x = mb_r;
        mul_y = qa_r;
        state_nxt = S_COMB;
      end
      S_COMB: state_nxt = S_RED;
      S_RED:  state_nxt = (mag_r == '0) ? S_IDLE : S_GCD;
      S_RN: begin
        div_start = 1'b1;
        div_n     = mag_r;
        div_d     = x_r;
        state_nxt = S_RNW;
      end
      S_RNW: if (div_done) state_nxt = S_RD;
      S_RD: begin
        div_start = 1'b1;
        div_n     = den_r;
        div_d     = x_r;
        state_nxt = S_RDW;
      end
      S_RDW: if (div_done) state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign prod = {32'd0, mul_x} * {32'd0, mul_y};
  assign ovf  = (den_r > LIM - 64'd1) || (neg_r ? (mag_r > LIM) : (mag_r > LIM - 64'd1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (state_r == S_CHECK && (da_r == '0 || db_r == '0)) out_valid_r <= 1'b1;
      if (state_r == S_RED && mag_r == '0)                  out_valid_r <= 1'b1;
      if (state_r == S_OUT)                                 out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        act_r <= in_data.action;
        ma_r  <= mag32(in_data.a_num);
        da_r  <= mag32(in_data.a_den);
        mb_r  <= mag32(in_data.b_num);
        db_r  <= mag32(in_data.b_den);
        sa_r  <= in_data.a_num[31] ^ in_data.a_den[31];
        sb_r  <= in_data.b_num[31] ^ in_data.b_den[31];
      end
      S_CHECK: begin
        x_r     <= {32'd0, da_r};
        y_r     <= {32'd0, db_r};
        phase_r <= 1'b0;
        out_r   <= '{res_num: '0, res_den: 31'd1, status: ST_ZDEN};
      end
      S_MULN: begin
        mag_r <= prod;
        neg_r <= sa_r ^ sb_r;
      end
      S_MULD: den_r <= prod;
      S_GCDW: begin
        if (div_done) begin
          x_r <= y_r;
          y_r <= div_rem;
        end
      end
      S_QAW:  if (div_done) qa_r <= div_q[31:0];
      S_QBW:  if (div_done) qb_r <= div_q[31:0];
      S_LCD:  den_r <= prod;
      S_TA:   ta_r <= prod;
      S_TB:   tb_r <= prod;
      S_COMB: begin
        if (sa_r == sb_r) begin
          mag_r <= ta_r + tb_r;
          neg_r <= sa_r;
        end else if (ta_r >= tb_r) begin
          mag_r <= ta_r - tb_r;
          neg_r <= sa_r;
        end else begin
          mag_r <= tb_r - ta_r;
          neg_r <= sb_r;
        end
      end
      S_RED: begin
        // seed the reduction gcd with (mag, den)
        x_r     <= mag_r;
        y_r     <= den_r;
        phase_r <= 1'b1;
        out_r   <= '{res_num: '0, res_den: 31'd1, status: ST_OK};
      end
      S_RNW:  if (div_done) mag_r <= div_q;
      S_RDW:  if (div_done) den_r <= div_q;
      S_OUT: begin
        if (ovf) begin
          out_r <= '{res_num: '0, res_den: 31'd1, status: ST_OVF};
        end else begin
          out_r.res_num <= neg_r ? (32'd0 - mag_r[31:0]) : mag_r[31:0];
          out_r.res_den <= den_r[30:0];
          out_r.status  <= ST_OK;
        end
      end
      default: ;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted word");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |->
      (out_data.res_num == '0 && out_data.res_den == 31'd1))
    else $error("error result not 0/1");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.res_den != '0))
    else $error("zero denominator on output");

endmodule
`default_nettype wire

/* bench/tb_rational_add_multiply_reduce_unit.sv */
// Testbench: random and directed fraction add/multiply words checked against a local predictor.
`timescale 1ns / 1ps
module tb_rational_add_multiply_reduce_unit;
  import rama_pkg::*;

  localparam int WB = 32;
  localparam int RANDOM_WORDS = 1600;
  localparam longint CYCLE_LIMIT = 60000000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_data = '0;
  logic      out_valid;
  out_word_t out_data;

  in_word_t  pending_words[$];
  out_word_t expected_fractions[$];
  logic      word_taken = 1'b0;
  int        gap_left = 0;
  int        sent_count = 0;
  int        checked_count = 0;
  int        error_count = 0;
  int        add_count = 0;
  int        mul_count = 0;
  int        zden_count = 0;
  int        ovf_count = 0;
  longint    cycle_count = 0;

  rational_add_multiply_reduce_unit #(.WORD_BITS(WB)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
    logic [63:0] r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic logic [63:0] magnitude(logic [31:0] v);
    return v[31] ? (64'h1_0000_0000 - {32'b0, v}) : {32'b0, v};
  endfunction

  function automatic out_word_t reduced_fraction(in_word_t w);
    out_word_t   r;
    logic [63:0] ma, da, mb, db, mag, den, g, ta, tb, lim;
    logic        sa, sb, neg;
    r.res_num = '0;
    r.res_den = 31'd1;
    r.status = ST_OK;
    ma = magnitude(w.a_num);
    da = magnitude(w.a_den);
    mb = magnitude(w.b_num);
    db = magnitude(w.b_den);
    if (da == 0 || db == 0) begin
      r.status = ST_ZDEN;
      return r;
    end
    sa = w.a_num[31] ^ w.a_den[31];
    sb = w.b_num[31] ^ w.b_den[31];
    if (w.action == ACT_MUL) begin
      mag = ma * mb;
      den = da * db;
      neg = sa ^ sb;
    end else begin
      g = euclid_gcd(da, db);
      den = (da / g) * db;
      ta = ma * (db / g);
      tb = mb * (da / g);
      if (sa == sb) begin
        mag = ta + tb;
        neg = sa;
      end else if (ta >= tb) begin
        mag = ta - tb;
        neg = sa;
      end else begin
        mag = tb - ta;
        neg = sb;
      end
    end
    if (mag == 0) return r;
    g = euclid_gcd(mag, den);
    mag = mag / g;
    den = den / g;
    lim = 64'd1 << (WB - 1);
    if (den > lim - 1 || (neg ? (mag > lim) : (mag > lim - 1))) begin
      r.status = ST_OVF;
      return r;
    end
    r.res_num = neg ? (32'd0 - mag[31:0]) : mag[31:0];
    r.res_den = den[30:0];
    return r;
  endfunction

  function automatic logic [31:0] random_field();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $urandom_range(0, 40) - 20;
      5, 6: v = $urandom;
      7: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'hffff_ffff;
          3: v = 32'h0000_0001;
          default: v = 32'h0000_0000;
        endcase
      end
      default: begin
        v = $urandom_range(0, 65535);
        if ($urandom_range(0, 1)) v = 32'd0 - v;
      end
    endcase
    return v;
  endfunction

  function automatic in_word_t make_word(logic act, logic [31:0] an, logic [31:0] ad,
                                         logic [31:0] bn, logic [31:0] bd);
    in_word_t w;
    w.action = act;
    w.a_num = an;
    w.a_den = ad;
    w.b_num = bn;
    w.b_den = bd;
    return w;
  endfunction

  // Accept at the rising edge, record the expected fraction, check results.
  always @(posedge clk) begin
    out_word_t exp_w;
    cycle_count <= cycle_count + 1;
    word_taken <= rst_n && start && !busy;
    if (rst_n && start && !busy) begin
      expected_fractions.push_back(reduced_fraction(in_data));
      sent_count <= sent_count + 1;
      if (in_data.action == ACT_MUL) mul_count <= mul_count + 1;
      else add_count <= add_count + 1;
    end
    if (rst_n && out_valid) begin
      if (expected_fractions.size() == 0) begin
        $display("%0t: unexpected result num=%0d den=%0d status=%0d", $time,
                 out_data.res_num, out_data.res_den, out_data.status);
        error_count <= error_count + 1;
      end else begin
        exp_w = expected_fractions.pop_front();
        checked_count <= checked_count + 1;
        if (exp_w.status == ST_ZDEN) zden_count <= zden_count + 1;
        if (exp_w.status == ST_OVF) ovf_count <= ovf_count + 1;
        if (out_data.res_num !== exp_w.res_num || out_data.res_den !== exp_w.res_den ||
            out_data.status !== exp_w.status) begin
          $display("%0t: mismatch expected %0d/%0d status %0d, actual %0d/%0d status %0d",
                   $time, exp_w.res_num, exp_w.res_den, exp_w.status,
                   out_data.res_num, out_data.res_den, out_data.status);
          error_count <= error_count + 1;
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("rational_add_multiply_reduce_unit verification failed");
      $finish;
    end
  end

  // Drive at the falling edge; drop start for a random gap between words, or keep it high when the gap is zero.
  always @(negedge clk) begin
    int g;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && word_taken) begin
      g = ((sent_count / 64) % 3 == 1) ? 0 : $urandom_range(0, 15);
      if (g == 0 && pending_words.size() != 0) begin
        in_data <= pending_words.pop_front();
      end else begin
        start <= 1'b0;
      end
      gap_left <= g;
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_words.size() != 0) begin
        start <= 1'b1;
        in_data <= pending_words.pop_front();
      end
    end
  end

  initial begin
    int i;
    logic [31:0] an, ad, bn, bd;
    // Directed: zero denominators, zero results, extremes, overflow, sign handling.
    pending_words.push_back(make_word(ACT_ADD, 32'd1, 32'd0, 32'd1, 32'd2));
    pending_words.push_back(make_word(ACT_MUL, 32'd1, 32'd2, 32'd3, 32'd0));
    pending_words.push_back(make_word(ACT_ADD, 32'd0, 32'd0, 32'd0, 32'd0));
    pending_words.push_back(make_word(ACT_ADD, 32'd0, 32'd5, 32'd0, 32'd7));
    pending_words.push_back(make_word(ACT_MUL, 32'd0, 32'd5, 32'd9, 32'd7));
    pending_words.push_back(make_word(ACT_ADD, 32'd1, 32'd2, -32'sd1, 32'd2));
    pending_words.push_back(make_word(ACT_ADD, 32'd1, 32'd2, 32'd1, 32'd3));
    pending_words.push_back(make_word(ACT_ADD, -32'sd3, 32'd4, 32'd1, -32'sd6));
    pending_words.push_back(make_word(ACT_MUL, 32'd2, -32'sd3, -32'sd9, -32'sd4));
    pending_words.push_back(make_word(ACT_MUL, 32'h8000_0000, 32'd1, 32'd1, 32'd1));
    pending_words.push_back(make_word(ACT_MUL, 32'h8000_0000, 32'd1, 32'hffff_ffff, 32'd1));
    pending_words.push_back(make_word(ACT_MUL, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1));
    pending_words.push_back(make_word(ACT_ADD, 32'h7fff_ffff, 32'd1, 32'd1, 32'd1));
    pending_words.push_back(make_word(ACT_ADD, 32'h8000_0000, 32'd1, 32'hffff_ffff, 32'd1));
    pending_words.push_back(make_word(ACT_ADD, 32'd1, 32'h7fff_ffff, 32'd1, 32'h7fff_fffe));
    pending_words.push_back(make_word(ACT_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000));
    pending_words.push_back(make_word(ACT_ADD, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                                      32'h7fff_ffff));
    pending_words.push_back(make_word(ACT_MUL, 32'd1, 32'h8000_0000, 32'd1, 32'h7fff_ffff));
    pending_words.push_back(make_word(ACT_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'd6, 32'd4));
    pending_words.push_back(make_word(ACT_MUL, 32'd6, 32'd4, 32'd10, 32'd15));
    for (i = 0; i < RANDOM_WORDS; i++) begin
      an = random_field();
      ad = random_field();
      bn = random_field();
      bd = random_field();
      pending_words.push_back(make_word(1'($urandom_range(0, 1)), an, ad, bn, bd));
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    while (pending_words.size() != 0 || start || expected_fractions.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d words (%0d add, %0d multiply); checked %0d results,", sent_count,
             add_count, mul_count, checked_count);
    $display("of which %0d zero-denominator and %0d overflow cases.", zden_count, ovf_count);
    if (error_count == 0 && expected_fractions.size() == 0) begin
      $display("rational_add_multiply_reduce_unit verification clean");
    end else begin
      $display("rational_add_multiply_reduce_unit verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/rama_pkg.sv
sv/rama_div.sv
sv/rational_add_multiply_reduce_unit.sv
bench/tb_rational_add_multiply_reduce_unit.sv
